### rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared widths, reset values and codes of the sensor baseline calibrator.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int SBC_WINDOW = 16;

	localparam int OP_W     = 2;
	localparam int ADC_W    = 10;
	localparam int FACTOR_W = 40;
	localparam int LOAD_W   = 20;
	localparam int RES_W    = 32;
	localparam int SUM_W    = 36;
	localparam int AVG_W    = 40;
	localparam int CFG_W    = 40;
	localparam int CFG_IDX_W = 1;

	localparam int DIV_W   = SUM_W + 8;
	localparam int DVSR_W  = ADC_W;
	localparam int CNT_W   = 6;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(64'd1024000000);
	localparam logic [LOAD_W-1:0]   LOAD_RESET   = LOAD_W'(32'd1000000);

	localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_FACTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES      = 1'b1;

endpackage

### rtl/sbc_ram.sv
// ----------------------------------------------------------------------------
// sbc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/sensor_baseline_calibrator.sv
// ----------------------------------------------------------------------------
// sensor_baseline_calibrator
// Converts converter samples to sensor resistance with a bit-serial divider,
// keeps a moving window sum and latches the average as baseline once two
// consecutive window averages agree.
// ----------------------------------------------------------------------------
// A step item runs the serial divider for the resistance, and runs it once more for an
// average over a window that is not a power of two; a zero sample skips the resistance
// division, and restart, cancel and code 3 go straight to the output. The serial divider
// makes one quotient bit per cycle.
// Input is ready again in the cycle after each result is loaded, so no new item is taken
// before the last one is through. Reset clears calibration state and loads the registers.
module sensor_baseline_calibrator
	import sbc_pkg::*;
#(
	parameter int WINDOW = SBC_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      operation,
	input  logic [ADC_W-1:0]     adc_sample,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RES_W-1:0]     resistance,
	output logic                 window_full,
	output logic [AVG_W-1:0]     average_x256,
	output logic                 finished,
	output logic [AVG_W-1:0]     baseline_x256
);

	localparam int  POS_W    = $clog2(WINDOW);
	localparam int  WIN_LOG  = $clog2(WINDOW);
	localparam bit  WIN_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RES,
		S_SUM,
		S_AVG,
		S_ADIV,
		S_OUT
	} state_t;

	state_t state_q;

	logic [FACTOR_W-1:0] factor_q;
	logic [LOAD_W-1:0]   load_q;

	logic [DIV_W-1:0]  div_d_q;
	logic [DVSR_W-1:0] div_r_q;
	logic [DVSR_W-1:0] div_v_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              zero_q;

	logic [RES_W-1:0] res_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] prev_q;
	logic [POS_W-1:0] pos_q;
	logic             filled_q;
	logic [AVG_W-1:0] avg_q;
	logic             base_hit_q;
	logic             bvalid_q;
	logic [AVG_W-1:0] bavg_q;

	logic [RES_W-1:0] ram_rdata;
	logic             ram_we;

	logic [DVSR_W:0]   trial;
	logic              trial_ge;
	logic [DVSR_W:0]   trial_diff;
	logic [DVSR_W-1:0] div_r_next;
	logic [DIV_W-1:0]  div_d_next;

	logic [FACTOR_W-1:0] quot;
	logic [FACTOR_W-1:0] quot_less;
	logic [RES_W-1:0]    res_calc;

	logic [RES_W-1:0] old_entry;
	logic [SUM_W-1:0] sum_next;
	logic             last_pos;
	logic             filled_next;

	logic [DIV_W-1:0] avg_shifted;
	logic             out_free;

	always_comb begin
		trial      = {div_r_q, div_d_q[DIV_W-1]};
		trial_ge   = trial >= {1'b0, div_v_q};
		trial_diff = trial - {1'b0, div_v_q};
		div_r_next = trial_ge ? trial_diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
		div_d_next = {div_d_q[DIV_W-2:0], trial_ge};
	end

	always_comb begin
		quot      = div_d_q[FACTOR_W-1:0];
		quot_less = quot - {{(FACTOR_W-LOAD_W){1'b0}}, load_q};
		if (zero_q) begin
			res_calc = '1;
		end else if (quot < {{(FACTOR_W-LOAD_W){1'b0}}, load_q}) begin
			res_calc = '0;
		end else if (quot_less[FACTOR_W-1:RES_W] != '0) begin
			res_calc = '1;
		end else begin
			res_calc = quot_less[RES_W-1:0];
		end
	end

	always_comb begin
		old_entry   = filled_q ? ram_rdata : '0;
		sum_next    = sum_q - {{(SUM_W-RES_W){1'b0}}, old_entry}
		              + {{(SUM_W-RES_W){1'b0}}, res_q};
		last_pos    = (pos_q == POS_W'(WINDOW - 1));
		filled_next = filled_q | last_pos;
		avg_shifted = {sum_q, 8'b0} >> WIN_LOG;
		ram_we      = (state_q == S_SUM);
		out_free    = !out_valid || out_ready;
	end

	assign in_ready = (state_q == S_IDLE);

	sbc_ram #(
		.WIDTH(RES_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(res_q),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			load_q   <= LOAD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SUPPLY_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_LOAD_RES:      load_q   <= cfg_data[LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sum_q      <= '0;
			prev_q     <= '0;
			pos_q      <= '0;
			filled_q   <= 1'b0;
			bvalid_q   <= 1'b0;
			base_hit_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q      <= '0;
						zero_q     <= (adc_sample == '0);
						base_hit_q <= 1'b0;
						div_d_q    <= {factor_q, {(DIV_W-FACTOR_W){1'b0}}};
						div_r_q    <= '0;
						div_v_q    <= adc_sample;
						div_cnt_q  <= CNT_W'(FACTOR_W);
						priority if (operation == OP_STEP) begin
							state_q <= (adc_sample == '0) ? S_RES : S_DIV;
						end else if (operation == OP_RESTART) begin
							sum_q    <= '0;
							prev_q   <= '0;
							pos_q    <= '0;
							filled_q <= 1'b0;
							bvalid_q <= 1'b0;
							state_q  <= S_OUT;
						end else if (operation == OP_CANCEL) begin
							bvalid_q <= 1'b0;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIV: begin
					div_d_q   <= div_d_next;
					div_r_q   <= div_r_next;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNT_W'(1)) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					res_q   <= res_calc;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q    <= sum_next;
					pos_q    <= last_pos ? '0 : pos_q + 1'b1;
					filled_q <= filled_next;
					if (filled_next) begin
						base_hit_q <= (sum_next == prev_q) && (sum_next != '0);
						prev_q     <= sum_next;
					end
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (WIN_POW2) begin
						avg_q <= avg_shifted[AVG_W-1:0];
						if (base_hit_q) begin
							bavg_q   <= avg_shifted[AVG_W-1:0];
							bvalid_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else begin
						div_d_q   <= {sum_q, 8'b0};
						div_r_q   <= '0;
						div_v_q   <= DVSR_W'(WINDOW);
						div_cnt_q <= CNT_W'(DIV_W);
						state_q   <= S_ADIV;
					end
				end
				S_ADIV: begin
					div_d_q   <= div_d_next;
					div_r_q   <= div_r_next;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNT_W'(1)) begin
						avg_q <= div_d_next[AVG_W-1:0];
						if (base_hit_q) begin
							bavg_q   <= div_d_next[AVG_W-1:0];
							bvalid_q <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						resistance    <= res_q;
						window_full   <= filled_q;
						average_x256  <= filled_q ? avg_q : '0;
						finished      <= bvalid_q;
						baseline_x256 <= bvalid_q ? bavg_q : '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!filled_q && pos_q == '0) |-> (sum_q == '0))
		else $error("window sum nonzero with empty ring");

	a_base_filled: assert property (@(posedge clk) disable iff (!arst_n)
		bvalid_q |-> filled_q)
		else $error("baseline present before the ring filled");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_full) |-> (average_x256 == '0))
		else $error("average shown for unfilled ring");

	a_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !finished) |-> (baseline_x256 == '0))
		else $error("baseline shown while not finished");

endmodule
